// ===== src/upud_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the url percent / utf-8 decoder
// no dependencies; used by upud_decode, upud_serializer and the top level

package upud_pkg;

   localparam int CP_W      = 31;
   localparam int MAX_RSP   = 3;

   localparam logic [7:0] CHAR_PLUS    = 8'd43;
   localparam logic [7:0] CHAR_PERCENT = 8'd37;
   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_QMARK   = 8'd63;

   typedef enum logic [1:0] {
      PH_NORMAL  = 2'd0,
      PH_PERCENT = 2'd1,
      PH_DIGIT   = 2'd2
   } phase_type;

   typedef struct packed {
      phase_type        pct_phase;
      logic [7:0]       held_digit;
      logic [2:0]       seq_remaining;
      logic [2:0]       seq_total;
      logic [CP_W-1:0]  seq_accum;
   } ustate_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic             cut_short;
      logic             no_char;
      logic             end_of_string;
   } rsp_type;

   // up to three results caused by one input word
   typedef struct packed {
      logic [1:0]              count;
      rsp_type [MAX_RSP-1:0]   slot;
   } pkt_type;

endpackage

// ===== src/upud_decode.sv =====
`timescale 1ns / 1ps
// percent decode and utf-8 assembly for one byte, plus the decoder state
// depends on upud_pkg

module upud_decode (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   input  logic               take,
   output upud_pkg::pkt_type  pkt
);

   typedef struct packed {
      upud_pkg::ustate_type        st;
      logic                        hit;
      logic [upud_pkg::CP_W-1:0]   cp;
   } feed_type;

   upud_pkg::ustate_type state_ff;
   upud_pkg::ustate_type state_in;
   upud_pkg::ustate_type st;
   feed_type             f_a;
   feed_type             f_b;
   upud_pkg::rsp_type    cand [4];
   logic [3:0]           cand_v;
   logic [1:0]           cnt;
   logic [7:0]           hex_byte;

   function automatic logic is_hex(logic [7:0] b);
      return b inside {[8'd48:8'd57], [8'd65:8'd70], [8'd97:8'd102]};
   endfunction

   // letters sit at 0x41/0x61 and up, so the low nibble plus nine
   function automatic logic [3:0] hex_val(logic [7:0] b);
      return b[6] ? (b[3:0] + 4'd9) : b[3:0];
   endfunction

   function automatic feed_type utf8_feed(upud_pkg::ustate_type s, logic [7:0] b);
      feed_type f;
      f.st  = s;
      f.hit = 1'b0;
      f.cp  = '0;
      if (s.seq_remaining != 3'd0) begin
         f.st.seq_accum     = {s.seq_accum[upud_pkg::CP_W-7:0], b[5:0]};
         f.st.seq_remaining = s.seq_remaining - 3'd1;
         if (f.st.seq_remaining == 3'd0) begin
            f.hit          = 1'b1;
            f.cp           = f.st.seq_accum;
            f.st.seq_accum = '0;
            f.st.seq_total = 3'd0;
         end
      end else if (!b[7]) begin
         f.hit = 1'b1;
         f.cp  = upud_pkg::CP_W'(b);
      end else if (b[7:5] == 3'b110) begin
         f.st.seq_accum     = upud_pkg::CP_W'(b[4:0]);
         f.st.seq_total     = 3'd2;
         f.st.seq_remaining = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
         f.st.seq_accum     = upud_pkg::CP_W'(b[3:0]);
         f.st.seq_total     = 3'd3;
         f.st.seq_remaining = 3'd2;
      end else if (b[7:3] == 5'b11110) begin
         f.st.seq_accum     = upud_pkg::CP_W'(b[2:0]);
         f.st.seq_total     = 3'd4;
         f.st.seq_remaining = 3'd3;
      end else if (b[7:2] == 6'b111110) begin
         f.st.seq_accum     = upud_pkg::CP_W'(b[1:0]);
         f.st.seq_total     = 3'd5;
         f.st.seq_remaining = 3'd4;
      end else if (b[7:1] == 7'b1111110) begin
         f.st.seq_accum     = upud_pkg::CP_W'(b[0]);
         f.st.seq_total     = 3'd6;
         f.st.seq_remaining = 3'd5;
      end else begin
         // bad lead byte
         f.hit = 1'b1;
         f.cp  = upud_pkg::CP_W'(upud_pkg::CHAR_QMARK);
      end
      return f;
   endfunction

   function automatic feed_type plain_byte(upud_pkg::ustate_type s, logic [7:0] b);
      feed_type f;
      f.st  = s;
      f.hit = 1'b0;
      f.cp  = '0;
      if (b == upud_pkg::CHAR_PLUS) begin
         f = utf8_feed(s, upud_pkg::CHAR_SPACE);
      end else if (b == upud_pkg::CHAR_PERCENT) begin
         f.st.pct_phase = upud_pkg::PH_PERCENT;
      end else begin
         f = utf8_feed(s, b);
      end
      return f;
   endfunction

   always_comb begin
      st       = state_ff;
      f_a      = '0;
      f_b      = '0;
      cand_v   = '0;
      hex_byte = {hex_val(state_ff.held_digit), hex_val(in_byte)};
      for (int k = 0; k < 4; k++) begin
         cand[k] = '0;
      end

      case (state_ff.pct_phase)
         upud_pkg::PH_PERCENT: begin
            if (is_hex(in_byte)) begin
               st.held_digit = in_byte;
               st.pct_phase  = upud_pkg::PH_DIGIT;
            end else begin
               st.pct_phase = upud_pkg::PH_NORMAL;
               f_b          = plain_byte(st, in_byte);
               st           = f_b.st;
            end
         end
         upud_pkg::PH_DIGIT: begin
            st.pct_phase = upud_pkg::PH_NORMAL;
            if (is_hex(in_byte)) begin
               f_a = utf8_feed(st, hex_byte);
               st  = f_a.st;
            end else begin
               // held digit goes on as a plain byte, then this byte as text
               f_a = utf8_feed(st, state_ff.held_digit);
               st  = f_a.st;
               f_b = plain_byte(st, in_byte);
               st  = f_b.st;
            end
         end
         default: begin
            st.pct_phase = upud_pkg::PH_NORMAL;
            f_b          = plain_byte(st, in_byte);
            st           = f_b.st;
         end
      endcase

      cand_v[0]          = f_a.hit;
      cand[0].code_point = f_a.cp;
      cand_v[1]          = f_b.hit;
      cand[1].code_point = f_b.cp;

      if (in_last) begin
         if (st.pct_phase == upud_pkg::PH_DIGIT) begin
            st.pct_phase = upud_pkg::PH_NORMAL;
            f_a          = utf8_feed(st, st.held_digit);
            st           = f_a.st;
            cand_v[2]          = f_a.hit;
            cand[2].code_point = f_a.cp;
         end
         if (st.seq_remaining != 3'd0) begin
            // open sequence, missing continuation bytes count as zero
            cand_v[3]          = 1'b1;
            cand[3].code_point = st.seq_accum << (5'(st.seq_remaining) * 5'd6);
            cand[3].cut_short  = 1'b1;
         end
      end

      pkt = '0;
      cnt = 2'd0;
      for (int k = 0; k < 4; k++) begin
         if (cand_v[k] && cnt != 2'd3) begin
            pkt.slot[cnt] = cand[k];
            cnt           = cnt + 2'd1;
         end
      end
      if (in_last) begin
         if (cnt == 2'd0) begin
            pkt.slot[0].no_char = 1'b1;
            cnt                 = 2'd1;
         end
         pkt.slot[cnt - 2'd1].end_of_string = 1'b1;
      end
      pkt.count = cnt;

      state_in = in_last ? '0 : st;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (take) begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/upud_serializer.sv =====
`timescale 1ns / 1ps
// result register holding up to three results of one input word,
// handed out one word per cycle while out_ready is high; depends on upud_pkg

module upud_serializer (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  upud_pkg::pkt_type  pkt,
   output logic               load_ready,
   output logic               out_valid,
   input  logic               out_ready,
   output upud_pkg::rsp_type  out_rsp
);

   upud_pkg::pkt_type pkt_ff;
   logic              valid_ff;
   logic [1:0]        idx_ff;
   logic              last_slot;
   logic              fire;

   assign last_slot  = (idx_ff == pkt_ff.count - 2'd1);
   assign fire       = valid_ff && out_ready;
   assign load_ready = !valid_ff || (out_ready && last_slot);
   assign out_valid  = valid_ff;
   assign out_rsp    = pkt_ff.slot[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= 1'b1;
         idx_ff   <= 2'd0;
      end else if (fire && last_slot) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (fire) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pkt_ff <= pkt;
      end
   end

endmodule

// ===== src/url_percent_utf8_decoder_unit.sv =====
`timescale 1ns / 1ps
// url percent decoder with utf-8 assembly, one text byte per word
// a byte goes from the input register through the decoder into the result register
// throughput: one byte per cycle while each byte gives at most one result
// and rsp_tready is high; a byte's k results hold the result register until taken
// reset: synchronous, clears the input register, result register and decoder state
// depends on upud_pkg, upud_decode, upud_serializer

module url_percent_utf8_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [30:0] code_point, [31] zero
   output logic [1:0]  rsp_tuser,   // [0] cut_short, [1] no_char
   output logic        rsp_tlast    // end_of_string
);

   logic              in_valid_ff;
   logic [7:0]        in_byte_ff;
   logic              in_last_ff;
   logic              take;
   logic              load_ready;
   upud_pkg::pkt_type pkt;
   upud_pkg::rsp_type out_rsp;

   // a byte that yields nothing never needs the result register
   assign take       = in_valid_ff && ((pkt.count == 2'd0) || load_ready);
   assign req_tready = !in_valid_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   upud_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .take    (take),
      .pkt     (pkt)
   );

   upud_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load       (take && (pkt.count != 2'd0)),
      .pkt        (pkt),
      .load_ready (load_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_rsp    (out_rsp)
   );

   assign rsp_tdata = {1'b0, out_rsp.code_point};
   assign rsp_tuser = {out_rsp.no_char, out_rsp.cut_short};
   assign rsp_tlast = out_rsp.end_of_string;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_marker_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == 32'd0 && !rsp_tuser[0] && rsp_tlast)
      else $error("end marker carries a character");

   a_cut_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("cut sequence not on the final result");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !take |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_last_ff))
      else $error("held input word lost");

endmodule
